// ----- rtl/hrc_pkg.sv -----
// ----------------------------------------------------------------------------
// hrc_pkg
// Types, constants and elaboration helpers shared by the Hamming row codec.
// ----------------------------------------------------------------------------
package hrc_pkg;

   localparam int WORD_W = 38;
   localparam int SYN_W  = 6;
   localparam int CSR_W  = 3;
   localparam int BYTE_W = 8;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [WORD_W-1:0] payload;
   } hrc_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic [SYN_W-1:0]  syndrome;
      logic              corrected;
      logic              syndrome_out_of_range;
   } hrc_rsp_type;

   // Smallest r with 2^r >= k + r + 1.
   function automatic int hrc_check_count(input int k);
      int r;
      r = 0;
      for (int i = 0; i < 8; i++) begin
         if ((1 << r) < k + r + 1) begin
            r = r + 1;
         end
      end
      return r;
   endfunction

   // Power-of-two positions carry check bits.
   function automatic logic hrc_is_check_pos(input int p);
      return ((p & (p - 1)) == 0);
   endfunction

endpackage

// ----- rtl/hrc_core.sv -----
// ----------------------------------------------------------------------------
// hrc_core
// Combinational encode and decode for every row size, selected by the size
// captured with the word.
// ----------------------------------------------------------------------------
module hrc_core #(
   parameter int MAX_BYTES = 4
) (
   input  hrc_pkg::hrc_req_type        req,
   input  logic [hrc_pkg::CSR_W-1:0]   row_bytes,
   output hrc_pkg::hrc_rsp_type        rsp
);
   import hrc_pkg::*;

   localparam int KMAX = MAX_BYTES * BYTE_W;
   localparam int NW   = KMAX + hrc_check_count(KMAX);

   logic [NW-1:0] word_ext;
   hrc_rsp_type   lane_rsp [1:MAX_BYTES];

   assign word_ext = NW'(req.payload);

   for (genvar gb = 1; gb <= MAX_BYTES; gb++) begin : g_lane
      localparam int K = gb * BYTE_W;
      localparam int R = hrc_check_count(K);
      localparam int N = K + R;

      logic [K-1:0]     enc_data;
      logic [N-1:0]     enc_cw;
      logic [R-1:0]     enc_chk;
      logic [N-1:0]     dec_cw;
      logic [N-1:0]     fix_cw;
      logic [K-1:0]     dec_data;
      logic [SYN_W-1:0] syn;
      logic             oor;

      // Encode: place data bits, then fill the check positions.
      always_comb begin
         int di;
         di       = 0;
         enc_data = word_ext[K-1:0];
         enc_cw   = '0;
         for (int p = 1; p <= N; p++) begin
            if (!hrc_is_check_pos(p)) begin
               enc_cw[N-p] = enc_data[K-1-di];
               di = di + 1;
            end
         end
         for (int i = 0; i < R; i++) begin
            enc_chk[i] = 1'b0;
            for (int p = 1; p <= N; p++) begin
               if (((p >> i) & 1) == 1) begin
                  enc_chk[i] = enc_chk[i] ^ enc_cw[N-p];
               end
            end
         end
         for (int i = 0; i < R; i++) begin
            enc_cw[N-(1<<i)] = enc_chk[i];
         end
      end

      // Decode: syndrome, single flip, strip check positions.
      always_comb begin
         int di;
         di     = 0;
         dec_cw = word_ext[N-1:0];
         for (int i = 0; i < SYN_W; i++) begin
            syn[i] = 1'b0;
            for (int p = 1; p <= N; p++) begin
               if (((p >> i) & 1) == 1) begin
                  syn[i] = syn[i] ^ dec_cw[N-p];
               end
            end
         end
         oor = (syn > SYN_W'(N));
         // an out-of-range or zero syndrome matches no position
         for (int p = 1; p <= N; p++) begin
            fix_cw[N-p] = dec_cw[N-p] ^ (syn == SYN_W'(p));
         end
         dec_data = '0;
         for (int p = 1; p <= N; p++) begin
            if (!hrc_is_check_pos(p)) begin
               dec_data[K-1-di] = fix_cw[N-p];
               di = di + 1;
            end
         end
      end

      always_comb begin
         if (req.operation == OP_ENCODE) begin
            lane_rsp[gb].result_word           = WORD_W'(enc_cw);
            lane_rsp[gb].syndrome              = '0;
            lane_rsp[gb].corrected             = 1'b0;
            lane_rsp[gb].syndrome_out_of_range = 1'b0;
         end else begin
            lane_rsp[gb].result_word           = WORD_W'(dec_data);
            lane_rsp[gb].syndrome              = syn;
            lane_rsp[gb].corrected             = (syn != '0) && !oor;
            lane_rsp[gb].syndrome_out_of_range = oor;
         end
      end
   end

   // row_bytes is already clamped to 1..MAX_BYTES
   always_comb begin
      rsp = lane_rsp[1];
      for (int b = 2; b <= MAX_BYTES; b++) begin
         if (row_bytes == CSR_W'(b)) begin
            rsp = lane_rsp[b];
         end
      end
   end

endmodule

// ----- rtl/hamming_row_codec_top.sv -----
// ----------------------------------------------------------------------------
// hamming_row_codec_top
// Path: a word accepted into req_ff is encoded or decoded by hrc_core and
// registered in rsp_ff, from where it shows on rsp_word with rsp_strobe.
// Throughput: one word per cycle whenever busy is low; busy drops after reset.
// Reset: synchronous; busy is high for the cycle after reset, row size
// returns to one byte and no result strobes until new words arrive.
// ----------------------------------------------------------------------------
module hamming_row_codec_top #(
   parameter int MAX_BYTES = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  hrc_pkg::hrc_req_type        req_word,
   output logic                        rsp_strobe,
   output hrc_pkg::hrc_rsp_type        rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [hrc_pkg::CSR_W-1:0]   csr_wdata
);
   import hrc_pkg::*;

   logic               busy_ff;
   logic               req_valid_ff;
   logic               rsp_strobe_ff;
   logic [CSR_W-1:0]   row_bytes_ff;
   logic [CSR_W-1:0]   row_bytes_in;
   hrc_req_type        req_ff;
   logic [CSR_W-1:0]   req_size_ff;
   hrc_rsp_type        rsp_in;
   hrc_rsp_type        rsp_ff;
   logic               accept;

   assign accept = start && !busy_ff;

   // clamp the row size on write
   always_comb begin
      if (csr_wdata == '0) begin
         row_bytes_in = CSR_W'(1);
      end else if (csr_wdata > CSR_W'(MAX_BYTES)) begin
         row_bytes_in = CSR_W'(MAX_BYTES);
      end else begin
         row_bytes_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         row_bytes_ff  <= CSR_W'(1);
      end else begin
         busy_ff       <= 1'b0;
         req_valid_ff  <= accept;
         rsp_strobe_ff <= req_valid_ff;
         if (csr_valid && csr_ready) begin
            row_bytes_ff <= row_bytes_in;
         end
      end
   end

   // hold the word and its row size together
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_word;
         req_size_ff <= row_bytes_ff;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   hrc_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .req       (req_ff),
      .row_bytes (req_size_ff),
      .rsp       (rsp_in)
   );

   assign busy       = busy_ff;
   assign csr_ready  = !busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- rtl/hrc_checker.sv -----
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks on the Hamming row codec, bound to the top level.
// ----------------------------------------------------------------------------
module hrc_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  hrc_pkg::hrc_req_type   req_word,
   input  logic                   rsp_strobe,
   input  hrc_pkg::hrc_rsp_type   rsp_word
);
   import hrc_pkg::*;

   // every accepted word yields a result strobe if reset stays low
   a_word_yields_result: assert property (@(posedge clock)
      (start && !busy && !reset) ##1 !reset |=> rsp_strobe)
      else $error("accepted word produced no result");

   a_result_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result strobe without an accepted word");

   a_encode_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(start && !busy && req_word.operation == OP_ENCODE, 2))
      |-> (rsp_word.syndrome == '0 && !rsp_word.corrected
           && !rsp_word.syndrome_out_of_range))
      else $error("encode result carries decode status");

   a_status_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_word.corrected && rsp_word.syndrome_out_of_range)
                     && (rsp_word.syndrome != '0 || !rsp_word.corrected))
      else $error("inconsistent correction status");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

endmodule

bind hamming_row_codec_top hrc_checker u_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Hamming row codec: a short table of directed
// words, then random encode and decode traffic over all row sizes, with every
// result word compared field by field against its table value or an in-bench SEC codec model.
// ----------------------------------------------------------------------------
module tb;
   import hrc_pkg::*;

   localparam int                ROW_BYTES_MAX = 4;
   localparam logic [WORD_W-1:0] ALL_ONES      = '1;

   typedef struct {
      logic [CSR_W-1:0]  rbytes;
      logic              op;
      logic [WORD_W-1:0] pl;
      bit                typed;
      hrc_rsp_type       want;
   } vector_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   hrc_req_type req_word;
   logic        rsp_strobe;
   hrc_rsp_type rsp_word;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_W-1:0] csr_wdata;

   hrc_rsp_type      codec_results[$];
   vector_row_type   directed[$];
   logic [CSR_W-1:0] row_bytes_model;
   hrc_rsp_type      head_word;
   int               error_count;
   int               encode_count;
   int               decode_count;
   int               fix_count;
   int               oor_count;

   hamming_row_codec_top #(
      .MAX_BYTES (ROW_BYTES_MAX)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // ---------------- codec model ----------------

   function automatic int effective_bytes(input logic [CSR_W-1:0] rb);
      int b;
      b = int'(rb);
      if (b < 1) b = 1;
      if (b > ROW_BYTES_MAX) b = ROW_BYTES_MAX;
      return b;
   endfunction

   // Smallest check count that covers data plus check positions.
   function automatic int check_bits(input int k);
      int r;
      r = 0;
      while ((1 << r) < k + r + 1) r++;
      return r;
   endfunction

   function automatic int position_syndrome(input logic [63:0] cw, input int n);
      int s;
      s = 0;
      for (int p = 1; p <= n; p++) begin
         if (cw[n-p]) s = s ^ p;
      end
      return s;
   endfunction

   function automatic hrc_rsp_type hamming_result(input logic op,
                                                  input logic [WORD_W-1:0] pl,
                                                  input logic [CSR_W-1:0] rb);
      int          k;
      int          r;
      int          n;
      int          di;
      int          syn;
      logic [63:0] data;
      logic [63:0] cw;
      logic [63:0] res;
      hrc_rsp_type o;
      k   = 8 * effective_bytes(rb);
      r   = check_bits(k);
      n   = k + r;
      res = '0;
      o   = '0;
      if (op == OP_ENCODE) begin
         data = 64'(pl) & ((64'd1 << k) - 64'd1);
         cw   = '0;
         di   = 0;
         for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) begin
               cw[n-p] = data[k-1-di];
               di++;
            end
         end
         syn = position_syndrome(cw, n);
         for (int i = 0; i < r; i++) begin
            if (((syn >> i) & 1) != 0) cw[n-(1<<i)] = 1'b1;
         end
         res = cw;
      end else begin
         cw         = 64'(pl) & ((64'd1 << n) - 64'd1);
         syn        = position_syndrome(cw, n);
         o.syndrome = syn[SYN_W-1:0];
         if (syn > n) begin
            o.syndrome_out_of_range = 1'b1;
         end else if (syn != 0) begin
            cw[n-syn]   = ~cw[n-syn];
            o.corrected = 1'b1;
         end
         for (int p = 1; p <= n; p++) begin
            if ((p & (p - 1)) != 0) res = {res[62:0], cw[n-p]};
         end
      end
      o.result_word = res[WORD_W-1:0];
      return o;
   endfunction

   // ---------------- result checker ----------------

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (codec_results.size() == 0) begin
            $error("result word with nothing outstanding: %h", rsp_word);
            error_count++;
         end else begin
            head_word = codec_results.pop_front();
            if (rsp_word.result_word !== head_word.result_word) begin
               $error("result_word: expected %h, got %h",
                      head_word.result_word, rsp_word.result_word);
               error_count++;
            end
            if (rsp_word.syndrome !== head_word.syndrome) begin
               $error("syndrome: expected %0d, got %0d",
                      head_word.syndrome, rsp_word.syndrome);
               error_count++;
            end
            if (rsp_word.corrected !== head_word.corrected) begin
               $error("corrected: expected %b, got %b",
                      head_word.corrected, rsp_word.corrected);
               error_count++;
            end
            if (rsp_word.syndrome_out_of_range !== head_word.syndrome_out_of_range) begin
               $error("syndrome_out_of_range: expected %b, got %b",
                      head_word.syndrome_out_of_range, rsp_word.syndrome_out_of_range);
               error_count++;
            end
         end
      end
   end

   // ---------------- drivers ----------------

   // Hold start until the word is taken, then, for a nonzero gap, drop start and idle.
   task automatic push_word(input logic op, input logic [WORD_W-1:0] pl,
                            input bit typed, input hrc_rsp_type want, input int gap);
      hrc_rsp_type exp_word;
      start             <= 1'b1;
      req_word.operation <= op;
      req_word.payload   <= pl;
      do @(posedge clock); while (busy);
      exp_word = typed ? want : hamming_result(op, pl, row_bytes_model);
      codec_results = {codec_results, exp_word};
      if (op == OP_ENCODE) encode_count++;
      else decode_count++;
      if (exp_word.corrected) fix_count++;
      if (exp_word.syndrome_out_of_range) oor_count++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (codec_results.size() != 0) @(posedge clock);
   endtask

   // Row size changes only with the pipeline empty.
   task automatic set_row_bytes(input logic [CSR_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      row_bytes_model = value;
   endtask

   task automatic add_vector(input logic [CSR_W-1:0] rb, input logic op,
                             input logic [WORD_W-1:0] pl, input bit typed,
                             input logic [WORD_W-1:0] word, input logic [SYN_W-1:0] syn,
                             input logic fix, input logic oor);
      vector_row_type row;
      row.rbytes                     = rb;
      row.op                         = op;
      row.pl                         = pl;
      row.typed                      = typed;
      row.want.result_word           = word;
      row.want.syndrome              = syn;
      row.want.corrected             = fix;
      row.want.syndrome_out_of_range = oor;
      directed = {directed, row};
   endtask

   // ---------------- stimulus ----------------

   initial begin
      int               rb_plan[10];
      int               idle_plan[3];
      int               idle_pct;
      int               gap;
      int               k;
      int               n;
      int               kind;
      int               flips;
      logic [63:0]      rnd;
      logic [63:0]      cw;
      logic [WORD_W-1:0] pl;
      logic             op;
      hrc_rsp_type      enc_word;

      rb_plan   = '{1, 4, 0, 7, 2, 3, 5, 6, 4, 1};
      idle_plan = '{0, 65, 25};
      error_count  = 0;
      encode_count = 0;
      decode_count = 0;
      fix_count    = 0;
      oor_count    = 0;
      row_bytes_model = 3'd1;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_word  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset row size of one byte: zero words, extremes, clean and bad codewords.
      add_vector(3'd1, OP_ENCODE, '0,        1, '0,       6'd0,  1'b0, 1'b0);
      add_vector(3'd1, OP_DECODE, '0,        1, '0,       6'd0,  1'b0, 1'b0);
      add_vector(3'd1, OP_ENCODE, 38'hFF,    1, 38'hEEF,  6'd0,  1'b0, 1'b0);
      add_vector(3'd1, OP_ENCODE, ALL_ONES,  1, 38'hEEF,  6'd0,  1'b0, 1'b0);
      add_vector(3'd1, OP_DECODE, 38'hEEF,   1, 38'hFF,   6'd0,  1'b0, 1'b0);
      add_vector(3'd1, OP_DECODE, 38'hFFF,   1, 38'hFE,   6'd12, 1'b1, 1'b0);
      add_vector(3'd1, OP_DECODE, ALL_ONES,  1, 38'hFE,   6'd12, 1'b1, 1'b0);
      add_vector(3'd1, OP_DECODE, 38'h801,   1, 38'h01,   6'd13, 1'b0, 1'b1);
      add_vector(3'd1, OP_DECODE, 38'h6EF,   0, '0,       '0,    1'b0, 1'b0);
      add_vector(3'd1, OP_DECODE, 38'hEEE,   0, '0,       '0,    1'b0, 1'b0);
      // Zero row size behaves as one byte.
      add_vector(3'd0, OP_ENCODE, 38'hFF,    1, 38'hEEF,  6'd0,  1'b0, 1'b0);
      add_vector(3'd0, OP_DECODE, 38'h801,   1, 38'h01,   6'd13, 1'b0, 1'b1);
      // Oversized row size clamps to the widest row.
      add_vector(3'd7, OP_DECODE, ALL_ONES,  1, 38'hFFFF_FFFF, 6'd39, 1'b0, 1'b1);
      add_vector(3'd7, OP_ENCODE, 38'hFFFF_FFFF, 0, '0, '0, 1'b0, 1'b0);
      add_vector(3'd4, OP_ENCODE, 38'hFFFF_FFFF, 0, '0, '0, 1'b0, 1'b0);
      add_vector(3'd4, OP_ENCODE, 38'h8000_0001, 0, '0, '0, 1'b0, 1'b0);
      add_vector(3'd4, OP_DECODE, ALL_ONES,  1, 38'hFFFF_FFFF, 6'd39, 1'b0, 1'b1);
      add_vector(3'd4, OP_DECODE, '0,        1, '0,       6'd0,  1'b0, 1'b0);
      add_vector(3'd4, OP_DECODE, 38'h1,     0, '0,       '0,    1'b0, 1'b0);
      add_vector(3'd4, OP_DECODE, 38'h20_0000_0000, 0, '0, '0, 1'b0, 1'b0);
      add_vector(3'd2, OP_ENCODE, 38'hA5C3,  0, '0,       '0,    1'b0, 1'b0);
      add_vector(3'd2, OP_DECODE, 38'h3F_0F0F_F00F, 0, '0, '0, 1'b0, 1'b0);
      add_vector(3'd3, OP_ENCODE, 38'hFF_FFFF, 0, '0,     '0,    1'b0, 1'b0);
      add_vector(3'd3, OP_DECODE, 38'h123_4567, 0, '0,    '0,    1'b0, 1'b0);
      add_vector(3'd5, OP_ENCODE, 38'hDEAD_BEEF, 0, '0,   '0,    1'b0, 1'b0);

      foreach (directed[i]) begin
         if (directed[i].rbytes != row_bytes_model) set_row_bytes(directed[i].rbytes);
         push_word(directed[i].op, directed[i].pl, directed[i].typed, directed[i].want, 0);
      end

      // Random traffic: encodes of random words, and decodes of mostly real codewords with zero, one or two hits.
      for (int ph = 0; ph < 10; ph++) begin
         set_row_bytes(rb_plan[ph][CSR_W-1:0]);
         idle_pct = idle_plan[ph % 3];
         k = 8 * effective_bytes(row_bytes_model);
         n = k + check_bits(k);
         for (int j = 0; j < 93; j++) begin
            rnd = {$urandom, $urandom};
            case ($urandom_range(15))
               0:       rnd = '0;
               1:       rnd = '1;
               default: ;
            endcase
            op = 1'($urandom_range(1));
            if (op == OP_ENCODE) begin
               pl = rnd[WORD_W-1:0];
            end else begin
               kind = $urandom_range(9);
               if (kind < 2) begin
                  pl = rnd[WORD_W-1:0];
               end else begin
                  enc_word = hamming_result(OP_ENCODE, rnd[WORD_W-1:0], row_bytes_model);
                  cw       = 64'(enc_word.result_word);
                  flips = (kind < 4) ? 0 : (kind < 8) ? 1 : 2;
                  for (int f = 0; f < flips; f++) begin
                     cw[$urandom_range(n - 1)] ^= 1'b1;
                  end
                  // Junk above the codeword must be ignored.
                  if ($urandom_range(1) == 1) begin
                     cw = cw | ({$urandom, $urandom} & ~((64'd1 << n) - 64'd1));
                  end
                  pl = cw[WORD_W-1:0];
               end
            end
            gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
            push_word(op, pl, 0, '0, gap);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d encodes and %0d decodes over row sizes 0 to 7,",
               encode_count, decode_count);
      $display("including %0d single-bit fixes and %0d out-of-range syndromes.",
               fix_count, oor_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
